// ===== rtl/plma_pkg.sv =====
// Shared constants, codes and types for the per-label mean accumulator.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package plma_pkg;

    // Sizing
    localparam int MAX_LABELS  = 1024;
    localparam int SAMPLE_BITS = 32;
    localparam int ADDR_W      = $clog2(MAX_LABELS);

    // Field widths
    localparam int OP_W      = 2;
    localparam int LABEL_W   = 10;
    localparam int SAMPLE_W  = 32;
    localparam int CFG_W     = 11;
    localparam int SUM_W     = 64;
    localparam int CNT_W     = 32;
    localparam int MEAN_W    = 64;
    localparam int FRAC_BITS = 16;

    // Divider: dividend is |sum| << FRAC_BITS
    localparam int DIV_W      = SUM_W + FRAC_BITS;
    localparam int DIV_STEP_W = $clog2(DIV_W);

    // Label range compare width
    localparam int LIM_W = ($clog2(MAX_LABELS + 1) > CFG_W) ? $clog2(MAX_LABELS + 1) : CFG_W;

    localparam logic [CFG_W-1:0] LABEL_COUNT_RST = CFG_W'(1024);

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes on the input beat
    localparam logic [OP_W-1:0] OP_ACC   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        K_ACC   = 2'd0,
        K_READ  = 2'd1,
        K_CLEAR = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic                   ok;
        logic [LABEL_W-1:0]     label;
        logic [SAMPLE_BITS-1:0] sample;
    } cmd_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] mag;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             valid;
        logic [DIV_W-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/plma_if.sv =====
// Valid/ready channel interfaces for the input and result beats.
// Depends on plma_pkg for field widths.
`default_nettype none

interface plma_in_if import plma_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic [LABEL_W-1:0]         label;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output operation, output label, output sample, input ready);
    modport sink   (input valid, input operation, input label, input sample, output ready);
endinterface

interface plma_out_if import plma_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [LABEL_W-1:0]       label_out;
    logic signed [MEAN_W-1:0] mean;
    logic                     empty_res;
    logic                     bad_label;

    modport source (output valid, output label_out, output mean, output empty_res,
                    output bad_label, input ready);
    modport sink   (input valid, input label_out, input mean, input empty_res,
                    input bad_label, output ready);
endinterface

`default_nettype wire

// ===== rtl/plma_front.sv =====
// Front end: input handshake, label_count register, command decode.
// Depends on plma_pkg and plma_in_if.
`default_nettype none

module plma_front import plma_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    plma_in_if.sink               item,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    input  wire logic             init_busy,
    input  wire logic             q_full,
    output logic                  q_push,
    output cmd_t                  q_cmd
);

    logic [CFG_W-1:0] label_count_reg;
    logic             label_ok;
    logic             keep;
    kind_t            kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_count_reg <= LABEL_COUNT_RST;
        end
        else if (cfg_we)
        begin
            label_count_reg <= cfg_wdata;
        end
    end

    // label < min(label_count, MAX_LABELS)
    assign label_ok = (LIM_W'(item.label) < LIM_W'(label_count_reg)) &&
                      (LIM_W'(item.label) < LIM_W'(MAX_LABELS));

    always_comb
    begin
        kind = K_ACC;
        keep = 1'b0;
        unique case (item.operation)
            OP_ACC:
            begin
                kind = K_ACC;
                keep = label_ok;    // out-of-range samples are dropped here
            end
            OP_READ:
            begin
                kind = K_READ;
                keep = 1'b1;
            end
            OP_CLEAR:
            begin
                kind = K_CLEAR;
                keep = 1'b1;
            end
            default:
            begin
                kind = K_ACC;
                keep = 1'b0;
            end
        endcase
    end

    assign item.ready   = !q_full && !init_busy;
    assign q_push       = item.valid && item.ready && keep;
    assign q_cmd.kind   = kind;
    assign q_cmd.ok     = label_ok;
    assign q_cmd.label  = item.label;
    assign q_cmd.sample = item.sample[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/plma_fifo.sv =====
// Short command queue between front end and execution back end.
// Depends on plma_pkg.
`default_nettype none

module plma_fifo import plma_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head,
    output logic      full
);

    cmd_t              slot_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = slot_q[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_q[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/plma_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Computes (mag << FRAC_BITS) / divisor; depends on plma_pkg.
`default_nettype none

module plma_div import plma_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]      rem_reg;
    logic [DIV_W-1:0]      dq_reg;     // dividend shifts out, quotient shifts in
    logic [CNT_W-1:0]      dvs_reg;

    logic [CNT_W:0]   trial;
    logic [CNT_W+1:0] diff;
    logic             fits;
    logic [CNT_W-1:0] rem_next;

    assign trial    = {rem_reg, dq_reg[DIV_W-1]};
    assign diff     = {1'b0, trial} - {2'b00, dvs_reg};
    assign fits     = !diff[CNT_W+1];
    assign rem_next = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= DIV_STEP_W'(DIV_W - 1);
        end
        else if (busy_reg)
        begin
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dq_reg  <= {req.mag, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[DIV_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign rsp.valid = done_reg;
    assign rsp.quot  = dq_reg;

endmodule

`default_nettype wire

// ===== rtl/plma_back.sv =====
// Back end: sum/count store, read-modify-write with forwarding, clear sweep,
// result formatting and output register. Depends on plma_pkg and plma_out_if.
`default_nettype none

module plma_back import plma_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     head_valid,
    input  wire cmd_t     head,
    output logic          pop,
    output logic          init_busy,
    output div_req_t      div_req,
    input  wire div_rsp_t div_rsp,
    plma_out_if.source    result
);

    typedef enum logic [2:0] {
        ST_SWEEP = 3'b001,
        ST_RUN   = 3'b010,
        ST_DIV   = 3'b100
    } back_state_t;

    localparam logic [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
    localparam logic [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};

    back_state_t state_reg, state_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic init_reg, init_next;

    // Stage 1: command whose entry read is in rd_reg
    logic s1_valid_reg, s1_valid_next;
    cmd_t s1_reg;
    logic s1_done;

    entry_t store_mem [MAX_LABELS];
    entry_t rd_reg;
    logic [ADDR_W-1:0] rd_addr;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;

    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    entry_t            fwd_reg;

    logic neg_reg;

    logic                     out_valid_reg;
    logic [LABEL_W-1:0]       out_label_reg;
    logic [MEAN_W-1:0]        out_mean_reg;
    logic                     out_empty_reg;
    logic                     out_bad_reg;
    logic                     out_load;
    logic [MEAN_W-1:0]        load_mean;
    logic                     load_empty;
    logic                     load_bad;
    logic                     out_free;

    logic [ADDR_W-1:0] s1_addr;
    entry_t            cur;
    logic [SUM_W-1:0]  smp;
    logic [SUM_W-1:0]  sum_add;
    logic              add_ovf;
    logic [SUM_W-1:0]  sat_sum;
    logic              cnt_full;
    logic              cnt_zero;
    logic              neg;
    logic [SUM_W-1:0]  mag;
    logic              sc_over;
    logic [MEAN_W-1:0] sc_mag;
    logic [MEAN_W-1:0] sc_mean;
    logic              imm;
    logic [MEAN_W-1:0] imm_mean;
    logic              dv_over;
    logic [MEAN_W-1:0] dv_mean;

    assign s1_addr = ADDR_W'(s1_reg.label);

    // One-deep forward covers a write landing on the edge of our read
    assign cur = (fwd_valid_reg && (fwd_addr_reg == s1_addr)) ? fwd_reg : rd_reg;

    assign smp      = {{(SUM_W-SAMPLE_BITS){s1_reg.sample[SAMPLE_BITS-1]}}, s1_reg.sample};
    assign sum_add  = cur.sum + smp;
    assign add_ovf  = (cur.sum[SUM_W-1] == smp[SUM_W-1]) &&
                      (sum_add[SUM_W-1] != cur.sum[SUM_W-1]);
    assign sat_sum  = add_ovf ? (cur.sum[SUM_W-1] ? SUM_MIN : SUM_MAX) : sum_add;
    assign cnt_full = &cur.count;
    assign cnt_zero = (cur.count == '0);

    assign neg = cur.sum[SUM_W-1];
    assign mag = neg ? (~cur.sum + 1'b1) : cur.sum;

    // Background label: raw sum in Q.16
    assign sc_over = |mag[SUM_W-1:SUM_W-FRAC_BITS-1];
    assign sc_mag  = MEAN_W'({mag[SUM_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}});
    assign sc_mean = neg ? (sc_over ? MEAN_MIN : (~sc_mag + 1'b1))
                         : (sc_over ? MEAN_MAX : sc_mag);

    assign imm      = !s1_reg.ok || (s1_reg.label == '0) || cnt_zero;
    assign imm_mean = (s1_reg.ok && (s1_reg.label == '0)) ? sc_mean : '0;

    assign dv_over = |div_rsp.quot[DIV_W-1:MEAN_W-1];
    assign dv_mean = neg_reg ? (dv_over ? MEAN_MIN : (~div_rsp.quot[MEAN_W-1:0] + 1'b1))
                             : (dv_over ? MEAN_MAX : div_rsp.quot[MEAN_W-1:0]);

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        init_next       = init_reg;
        s1_done         = 1'b0;
        we              = 1'b0;
        waddr           = s1_addr;
        wdata.sum       = sat_sum;
        wdata.count     = cur.count + 1'b1;
        out_load        = 1'b0;
        load_mean       = imm_mean;
        load_empty      = s1_reg.ok && cnt_zero;
        load_bad        = !s1_reg.ok;
        div_req.start   = 1'b0;
        div_req.mag     = mag;
        div_req.divisor = cur.count;

        unique case (state_reg)
            ST_SWEEP:
            begin
                we    = 1'b1;
                waddr = sweep_reg;
                wdata = '0;
                if (sweep_reg == ADDR_W'(MAX_LABELS - 1))
                begin
                    sweep_next = '0;
                    init_next  = 1'b0;
                    state_next = ST_RUN;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_RUN:
            begin
                if (s1_valid_reg)
                begin
                    unique case (s1_reg.kind)
                        K_ACC:
                        begin
                            s1_done = 1'b1;
                            we      = !cnt_full;
                        end
                        K_READ:
                        begin
                            if (imm)
                            begin
                                if (out_free)
                                begin
                                    out_load = 1'b1;
                                    s1_done  = 1'b1;
                                end
                            end
                            else
                            begin
                                div_req.start = 1'b1;
                                state_next    = ST_DIV;
                            end
                        end
                        K_CLEAR:
                        begin
                            s1_done    = 1'b1;
                            state_next = ST_SWEEP;
                        end
                        default:
                        begin
                            s1_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_rsp.valid && out_free)
                begin
                    out_load   = 1'b1;
                    load_mean  = dv_mean;
                    load_empty = 1'b0;
                    load_bad   = 1'b0;
                    s1_done    = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_SWEEP;
            end
        endcase

        pop = (state_reg == ST_RUN) && (state_next == ST_RUN) && head_valid &&
              (!s1_valid_reg || s1_done);
        s1_valid_next = pop ? 1'b1 : (s1_done ? 1'b0 : s1_valid_reg);
        rd_addr = pop ? ADDR_W'(head.label) : s1_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_reg     <= '0;
            init_reg      <= 1'b1;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            init_reg     <= init_next;
            s1_valid_reg <= s1_valid_next;
            if (we)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Store: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        rd_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            fwd_addr_reg <= waddr;
            fwd_reg      <= wdata;
        end
        if (pop)
        begin
            s1_reg <= head;
        end
        if (div_req.start)
        begin
            neg_reg <= neg;
        end
        if (out_load)
        begin
            out_label_reg <= s1_reg.label;
            out_mean_reg  <= load_mean;
            out_empty_reg <= load_empty;
            out_bad_reg   <= load_bad;
        end
    end

    assign init_busy        = init_reg;
    assign result.valid     = out_valid_reg;
    assign result.label_out = out_label_reg;
    assign result.mean      = out_mean_reg;
    assign result.empty_res = out_empty_reg;
    assign result.bad_label = out_bad_reg;

endmodule

`default_nettype wire

// ===== rtl/per_label_mean_accumulator_unit.sv =====
// Top level of the per-label mean accumulator.
// Depends on plma_pkg, plma_if, plma_front, plma_fifo, plma_div, plma_back.
//
// Keeps a saturating 64-bit sum and a 32-bit sample count per label in a
// single-port-write / registered-read store. Operation 0 adds a sample to a
// label (ignored for labels at or above label_count, or when the count is
// full); operation 1 returns one result beat with the label's mean in signed
// Q47.16, truncated toward zero and saturated (label 0 returns its sum in
// Q.16; an empty label reads zero with empty_res; an out-of-range label gives
// bad_label); operation 2 zeroes every label. Operation 3 is dropped.
// Timing: accumulates and non-dividing reads sustain one beat per clock
// (reads while the output register is free) through a two-stage RMW with
// one-deep write forwarding. A read that divides holds the back end while
// the shared restoring divider makes its 80 quotient bits, one per clock.
// A clear sweeps the store, one entry per clock, over all MAX_LABELS (1024)
// entries. After reset the same sweep runs and item.ready stays low until
// it ends; label_count writes are taken at any time. Results wait in an
// output register while a two-beat command queue keeps accepting input.
// label_count is written through cfg_we/cfg_wdata and should only change
// while the block is idle.
`default_nettype none

module per_label_mean_accumulator_unit import plma_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    plma_in_if.sink               item,
    plma_out_if.source            result,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    logic     q_push;
    cmd_t     q_cmd;
    logic     q_full;
    logic     head_valid;
    cmd_t     head;
    logic     pop;
    logic     init_busy;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Decode, range check against label_count, drop no-op beats
    plma_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .init_busy (init_busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    // Decouples input acceptance from back-end stalls
    plma_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .full       (q_full)
    );

    // Mean division for reads of non-background labels
    plma_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Store, RMW pipeline, clear sweep, result register
    plma_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .init_busy  (init_busy),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .result     (result)
    );

endmodule

`default_nettype wire
